/* rtl/sbb_pkg.sv */
// Shared constants, register codes and types of the separable box blur.
`default_nettype none
package sbb_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 15;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam int RING_ROWS = 2 * MAX_RADIUS + 2;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int WV_W      = $clog2(MAX_WIDTH + 1);
    localparam int HV_W      = $clog2(MAX_HEIGHT + 1);
    localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
    localparam int SLOT_W    = $clog2(RING_ROWS);
    localparam int SLOTS_W   = $clog2(RING_ROWS + 1);
    localparam int TAP_W     = $clog2(2 * MAX_RADIUS + 2);
    localparam int SUM_W     = 8 + TAP_W;
    localparam int PCNT_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int MEM_DEPTH = RING_ROWS * MAX_WIDTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int XS_W      = WV_W + 2;
    localparam int YS_W      = HV_W + 2;

    localparam int REG_DIM_W = 11;
    localparam int REG_RAD_W = 4;
    localparam int PADDR_W   = 4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    typedef struct packed {
        logic [WV_W-1:0]  width;
        logic [HV_W-1:0]  height;
        logic [RAD_W-1:0] radius;
    } t_cfg;

    typedef struct packed {
        logic              wr;
        logic [SLOT_W-1:0] wslot;
        logic [COL_W-1:0]  wcol;
        logic [31:0]       pix;
        logic              emit;
        logic [COL_W-1:0]  ox;
        logic [ROW_W-1:0]  oy;
        logic [SLOT_W-1:0] oslot;
        logic              last;
    } t_job;
endpackage
`default_nettype wire

/* rtl/sbb_if.sv */
// Stream interfaces for source pixel requests and blurred pixel requests.
`default_nettype none
interface sbb_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] pixel_in;
    modport source(output valid, output kind, output pixel_in, input ready);
    modport sink(input valid, input kind, input pixel_in, output ready);
endinterface

interface sbb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;
    logic        frame_last;
    modport source(output valid, output pixel_out, output frame_last, input ready);
    modport sink(input valid, input pixel_out, input frame_last, output ready);
endinterface
`default_nettype wire

/* rtl/sbb_front.sv */
// Front end: accepts requests, tracks frame positions and issues jobs.
`default_nettype none
module sbb_front import sbb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sbb_in_if.sink    i_in,
    input  wire t_cfg i_cfg,
    input  wire logic i_restart,
    output logic      o_push,
    input  wire logic i_push_ready,
    output t_job      o_job
);
    logic [PCNT_W-1:0]  r_recv, r_emit;
    logic [COL_W-1:0]   r_in_col, r_out_col;
    logic [ROW_W-1:0]   r_out_row;
    logic [SLOT_W-1:0]  r_in_slot, r_out_slot;
    logic [PCNT_W-1:0]  total, delay, recv_n;
    logic [SLOTS_W-1:0] slots;
    logic               accept, wr, emit, last;

    assign total  = PCNT_W'(i_cfg.width * i_cfg.height);
    assign delay  = PCNT_W'(i_cfg.radius * i_cfg.width + i_cfg.radius);
    assign slots  = SLOTS_W'({i_cfg.radius, 1'b0}) + SLOTS_W'(2);
    assign wr     = !i_in.kind && (r_recv < total);
    assign recv_n = r_recv + PCNT_W'(wr);
    assign emit   = (r_emit < total) && ((recv_n == total) || ((recv_n - r_emit) > delay));
    assign last   = emit && ((r_emit + PCNT_W'(1)) == total);

    assign i_in.ready = i_push_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept && (wr || emit);

    assign o_job.wr    = wr;
    assign o_job.wslot = r_in_slot;
    assign o_job.wcol  = r_in_col;
    assign o_job.pix   = i_in.pixel_in;
    assign o_job.emit  = emit;
    assign o_job.ox    = r_out_col;
    assign o_job.oy    = r_out_row;
    assign o_job.oslot = r_out_slot;
    assign o_job.last  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart || (accept && last)) begin
            r_recv     <= '0;
            r_emit     <= '0;
            r_in_col   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_in_slot  <= '0;
            r_out_slot <= '0;
        end else if (accept) begin
            r_recv <= recv_n;
            r_emit <= r_emit + PCNT_W'(emit);
            if (wr) begin
                if ((WV_W'(r_in_col) + WV_W'(1)) >= i_cfg.width) begin
                    r_in_col <= '0;
                    if ((SLOTS_W'(r_in_slot) + SLOTS_W'(1)) == slots) begin
                        r_in_slot <= '0;
                    end else begin
                        r_in_slot <= r_in_slot + SLOT_W'(1);
                    end
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
            end
            if (emit) begin
                if ((WV_W'(r_out_col) + WV_W'(1)) >= i_cfg.width) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + ROW_W'(1);
                    if ((SLOTS_W'(r_out_slot) + SLOTS_W'(1)) == slots) begin
                        r_out_slot <= '0;
                    end else begin
                        r_out_slot <= r_out_slot + SLOT_W'(1);
                    end
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/sbb_fifo.sv */
// Job queue between the front end and the blur engine.
`default_nettype none
module sbb_fifo import sbb_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_job i_push_data,
    output logic      o_pop_valid,
    input  wire logic i_pop_ready,
    output t_job      o_pop_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push, pop;

    assign o_push_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(push) - CNT_W'(pop);
        end
    end
endmodule
`default_nettype wire

/* rtl/sbb_back.sv */
// Blur engine: owns the row store, sums the window taps and divides.
`default_nettype none
module sbb_back import sbb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_job_valid,
    output logic      o_job_ready,
    input  wire t_job i_job,
    sbb_out_if.source o_out
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam int DCNT_W = $clog2(SUM_W + 1);

    logic [31:0]        mem [MEM_DEPTH];
    logic [31:0]        r_rdata;
    logic [2:0]         r_state;
    logic [COL_W-1:0]   r_ox;
    logic               r_last;
    logic [SLOT_W-1:0]  r_slot;
    logic [YS_W-1:0]    r_ycur;
    logic [TAP_W-1:0]   r_i, r_j;
    logic [SUM_W-1:0]   r_hsum [4];
    logic [SUM_W-1:0]   r_vsum [4];
    logic [SUM_W-1:0]   r_dq [4];
    logic [TAP_W-1:0]   r_rem [4];
    logic [DCNT_W-1:0]  r_dcnt;
    logic               r_vert;
    logic [31:0]        r_res;
    logic               r_ovalid, r_olast;
    logic [31:0]        r_opix;

    logic               pop, we, re;
    logic [TAP_W-1:0]   taps_m1, divisor;
    logic [SLOTS_W-1:0] slots;
    logic [XS_W-1:0]    xs;
    logic [COL_W-1:0]   xx;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [YS_W-1:0]    ynext;
    logic               slot_adv;
    logic [SLOTS_W-1:0] start_slot;
    logic [SUM_W-1:0]   hsum_n [4];
    logic [SUM_W-1:0]   vsum_n [4];
    logic [SUM_W-1:0]   dq_nx [4];
    logic [TAP_W-1:0]   rem_nx [4];
    logic [TAP_W:0]     rem_sh [4];

    assign taps_m1 = TAP_W'({i_cfg.radius, 1'b0});
    assign divisor = TAP_W'({i_cfg.radius, 1'b1});
    assign slots   = SLOTS_W'({i_cfg.radius, 1'b0}) + SLOTS_W'(2);

    assign o_job_ready = (r_state == S_IDLE);
    assign pop = i_job_valid && o_job_ready;
    assign we  = pop && i_job.wr;
    assign re  = (r_state == S_RD);

    assign xs = XS_W'(r_ox) - XS_W'(i_cfg.radius) + XS_W'(r_j);
    always_comb begin
        if (xs[XS_W-1]) begin
            xx = '0;
        end else if (xs >= XS_W'(i_cfg.width)) begin
            xx = COL_W'(i_cfg.width - WV_W'(1));
        end else begin
            xx = COL_W'(xs);
        end
    end

    assign waddr = ADDR_W'(int'(i_job.wslot) * MAX_WIDTH + int'(i_job.wcol));
    assign raddr = ADDR_W'(int'(r_slot) * MAX_WIDTH + int'(xx));

    assign ynext    = r_ycur + YS_W'(1);
    assign slot_adv = !ynext[YS_W-1] && (ynext != '0) && (ynext < YS_W'(i_cfg.height));

    always_comb begin
        if (HV_W'(i_job.oy) < HV_W'(i_cfg.radius)) begin
            start_slot = '0;
        end else if (i_job.oslot >= SLOT_W'(i_cfg.radius)) begin
            start_slot = SLOTS_W'(i_job.oslot) - SLOTS_W'(i_cfg.radius);
        end else begin
            start_slot = SLOTS_W'(i_job.oslot) + slots - SLOTS_W'(i_cfg.radius);
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            hsum_n[k] = r_hsum[k] + SUM_W'(r_rdata[8*k +: 8]);
            rem_sh[k] = {r_rem[k], r_dq[k][SUM_W-1]};
            if (rem_sh[k] >= {1'b0, divisor}) begin
                rem_nx[k] = TAP_W'(rem_sh[k] - {1'b0, divisor});
                dq_nx[k]  = {r_dq[k][SUM_W-2:0], 1'b1};
            end else begin
                rem_nx[k] = TAP_W'(rem_sh[k]);
                dq_nx[k]  = {r_dq[k][SUM_W-2:0], 1'b0};
            end
            vsum_n[k] = r_vsum[k] + SUM_W'(dq_nx[k][7:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= i_job.pix;
        end
        if (re) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_OUT) && (!r_ovalid || o_out.ready)) begin
            r_ovalid <= 1'b1;
        end else if (o_out.valid && o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (pop && i_job.emit) begin
                        r_ox   <= i_job.ox;
                        r_last <= i_job.last;
                        r_ycur <= YS_W'(i_job.oy) - YS_W'(i_cfg.radius);
                        r_slot <= SLOT_W'(start_slot);
                        r_i    <= '0;
                        r_j    <= '0;
                        for (int k = 0; k < 4; k++) begin
                            r_hsum[k] <= '0;
                            r_vsum[k] <= '0;
                        end
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_j == taps_m1) begin
                        for (int k = 0; k < 4; k++) begin
                            r_dq[k]  <= hsum_n[k];
                            r_rem[k] <= '0;
                        end
                        r_dcnt  <= '0;
                        r_vert  <= 1'b0;
                        r_state <= S_DIV;
                    end else begin
                        for (int k = 0; k < 4; k++) begin
                            r_hsum[k] <= hsum_n[k];
                        end
                        r_j     <= r_j + TAP_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_DIV: begin
                    if (r_dcnt != DCNT_W'(SUM_W - 1)) begin
                        for (int k = 0; k < 4; k++) begin
                            r_dq[k]  <= dq_nx[k];
                            r_rem[k] <= rem_nx[k];
                        end
                        r_dcnt <= r_dcnt + DCNT_W'(1);
                    end else if (r_vert) begin
                        for (int k = 0; k < 4; k++) begin
                            r_res[8*k +: 8] <= dq_nx[k][7:0];
                        end
                        r_state <= S_OUT;
                    end else if (r_i == taps_m1) begin
                        for (int k = 0; k < 4; k++) begin
                            r_dq[k]  <= vsum_n[k];
                            r_rem[k] <= '0;
                        end
                        r_dcnt <= '0;
                        r_vert <= 1'b1;
                    end else begin
                        for (int k = 0; k < 4; k++) begin
                            r_vsum[k] <= vsum_n[k];
                            r_hsum[k] <= '0;
                        end
                        r_i    <= r_i + TAP_W'(1);
                        r_j    <= '0;
                        r_ycur <= ynext;
                        if (slot_adv) begin
                            if ((SLOTS_W'(r_slot) + SLOTS_W'(1)) == slots) begin
                                r_slot <= '0;
                            end else begin
                                r_slot <= r_slot + SLOT_W'(1);
                            end
                        end
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_opix   <= r_res;
                        r_olast  <= r_last;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.pixel_out  = r_opix;
    assign o_out.frame_last = r_olast;
endmodule
`default_nettype wire

/* rtl/separable_box_blur_argb_top.sv */
// Top level: configuration registers, front end, job queue and blur engine.
// An item that only stores a pixel is written to the row store and leaves the engine idle.
// An item that yields a result holds the engine while it reads the taps one at a time
// through the single row store read port and divides with the bit-serial divider.
// The front end takes one item per cycle while the job queue has room.
// Reset is synchronous: counters clear, registers return to 1024, 1024 and 0,
// and the row store keeps its contents.
`default_nettype none
module separable_box_blur_argb_top import sbb_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    sbb_in_if.sink                  i_in,
    sbb_out_if.source               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [REG_DIM_W-1:0] r_width, r_height;
    logic [REG_RAD_W-1:0] r_radius;
    logic [1:0]           idx;
    logic                 wr_en;
    t_cfg                 cfg;
    t_job                 push_job, pop_job;
    logic                 push, push_ready, pop_valid, pop_ready;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= REG_DIM_W'(1024);
            r_height <= REG_DIM_W'(1024);
            r_radius <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_WIDTH:  r_width  <= pwdata[REG_DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[REG_DIM_W-1:0];
                REG_RADIUS: r_radius <= pwdata[REG_RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            REG_RADIUS: prdata = 32'(r_radius);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        if (r_width == '0) begin
            cfg.width = WV_W'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            cfg.width = WV_W'(MAX_WIDTH);
        end else begin
            cfg.width = WV_W'(r_width);
        end
        if (r_height == '0) begin
            cfg.height = HV_W'(1);
        end else if (int'(r_height) > MAX_HEIGHT) begin
            cfg.height = HV_W'(MAX_HEIGHT);
        end else begin
            cfg.height = HV_W'(r_height);
        end
        if (int'(r_radius) > MAX_RADIUS) begin
            cfg.radius = RAD_W'(MAX_RADIUS);
        end else begin
            cfg.radius = RAD_W'(r_radius);
        end
    end

    sbb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (cfg),
        .i_restart    (wr_en),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_job        (push_job)
    );

    sbb_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push),
        .o_push_ready (push_ready),
        .i_push_data  (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_job)
    );

    sbb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (pop_valid),
        .o_job_ready (pop_ready),
        .i_job       (pop_job),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire

/* rtl/sbb_checker.sv */
// Port-level checks of the blur top level, attached by a bind statement.
`default_nettype none
module sbb_checker import sbb_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [31:0]        i_out_pixel,
    input wire logic               i_out_last,
    input wire logic               i_psel,
    input wire logic               i_penable,
    input wire logic               i_pwrite,
    input wire logic [PADDR_W-1:0] i_paddr,
    input wire logic [31:0]        i_pwdata,
    input wire logic [31:0]        i_prdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result request dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_pixel) && $stable(i_out_last))
        else $error("Stalled result request changed.");

    a_width_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && (i_paddr[3:2] == REG_WIDTH))
        ##1 (i_paddr[3:2] == REG_WIDTH)
        |-> (i_prdata[REG_DIM_W-1:0] == $past(i_pwdata[REG_DIM_W-1:0])))
        else $error("Width register reads back a wrong value.");

    a_reset_state: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid && i_in_ready)
        else $error("Block not empty after reset.");
endmodule

bind separable_box_blur_argb_top sbb_checker u_sbb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pixel (o_out.pixel_out),
    .i_out_last  (o_out.frame_last),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);
`default_nettype wire
